// ===== hdl/ple_pkg.sv =====
`default_nettype none

package ple_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int ACT_W        = 3;
    localparam int POS_W        = 7;
    localparam int CNT_OUT_W    = 7;

    // command codes; six and seven are no-ops
    typedef enum logic [ACT_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_POS   = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_BACK  = 3'd4,
        ACT_DEL_POS   = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // per-cell move for the current command
    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_REMOVE = 2'd2
    } t_shift;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [DATA_W-1:0] item_value;
        logic [POS_W-1:0]         position;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        logic [1:0]               status;
        logic [CNT_OUT_W-1:0]     entry_count;
    } t_result;

    // decoded command, shared by the decoder and the top level
    typedef struct packed {
        t_shift  op;
        t_status status;
    } t_dec;

    // broadcast to every cell
    typedef struct packed {
        t_shift                   op;
        logic signed [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== hdl/ple_cell.sv =====
`default_nettype none

module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  wire logic                     i_clk,
    input  wire t_cell_cmd                i_cmd,
    input  wire logic [IDX_W-1:0]         i_idx,
    input  wire logic signed [DATA_W-1:0] i_left,
    input  wire logic signed [DATA_W-1:0] i_right,
    output logic signed [DATA_W-1:0]      o_value
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_cmd.op)
            SH_INSERT: begin
                if (MY_IDX == i_idx) begin
                    n_value = i_cmd.value;
                end else if (MY_IDX > i_idx) begin
                    n_value = i_left;
                end
            end
            SH_REMOVE: begin
                if (MY_IDX >= i_idx) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ===== hdl/ple_ctrl.sv =====
`default_nettype none

module ple_ctrl
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  wire logic             i_valid,
    input  wire t_cmd             i_cmd,
    input  wire logic [CNT_W-1:0] i_count,
    output t_dec                  o_dec,
    output logic [IDX_W-1:0]      o_idx,
    output logic [CNT_W-1:0]      o_count_nxt
);

    // compare width covers both the position field and count + 1
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] pos_m1;
    logic [CNT_W-1:0] cnt_m1;
    logic             full;
    logic             pos_zero;

    assign cnt_x    = CMP_W'(i_count);
    assign pos_x    = CMP_W'(i_cmd.position);
    assign pos_m1   = pos_x - CMP_W'(1);
    assign cnt_m1   = i_count - CNT_W'(1);
    assign full     = (i_count >= CNT_W'(CAPACITY));
    assign pos_zero = (i_cmd.position == '0);

    always_comb begin
        o_dec.op     = SH_HOLD;
        o_dec.status = ST_OK;
        o_idx        = '0;
        o_count_nxt  = i_count;
        case (t_action'(i_cmd.action))
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
                if ((t_action'(i_cmd.action) == ACT_INS_POS) &&
                    (pos_zero || (pos_x > cnt_x + CMP_W'(1)))) begin
                    o_dec.status = ST_BADPOS;
                end else if (full) begin
                    o_dec.status = ST_FULL;
                end else begin
                    o_dec.op    = SH_INSERT;
                    o_count_nxt = i_count + CNT_W'(1);
                    case (t_action'(i_cmd.action))
                        ACT_INS_FRONT: o_idx = '0;
                        ACT_INS_BACK:  o_idx = i_count[IDX_W-1:0];
                        default:       o_idx = pos_m1[IDX_W-1:0];
                    endcase
                end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_POS: begin
                // empty list wins over a bad position
                if (i_count == '0) begin
                    o_dec.status = ST_EMPTY;
                end else if ((t_action'(i_cmd.action) == ACT_DEL_POS) &&
                             (pos_zero || (pos_x > cnt_x))) begin
                    o_dec.status = ST_BADPOS;
                end else begin
                    o_dec.op    = SH_REMOVE;
                    o_count_nxt = cnt_m1;
                    case (t_action'(i_cmd.action))
                        ACT_DEL_FRONT: o_idx = '0;
                        ACT_DEL_BACK:  o_idx = cnt_m1[IDX_W-1:0];
                        default:       o_idx = pos_m1[IDX_W-1:0];
                    endcase
                end
            end
            default: begin
                o_dec.op = SH_HOLD;
            end
        endcase
        // no command, no change
        if (!i_valid) begin
            o_dec.op    = SH_HOLD;
            o_count_nxt = i_count;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/positional_list_engine.sv =====
`default_nettype none

// Positional list engine: a bounded ordered list of signed 32-bit values.
//
// Command channel: drive i_cmd (action, item_value, position) with start high.
// The command transfers at the rising edge where start is high and busy is low.
// busy stays low: the list takes one command per clock.
//
// Result channel: the cycle after each transfer, o_done is high for exactly
// one cycle with o_result (removed_value, status, entry_count). The receiver
// cannot stall; it must take the result in that cycle.
//
// Throughput is one command per cycle. The list is a row of CAPACITY cells;
// on each command every cell decides on its own whether to hold, load the
// new value, or take its left or right neighbor's value, so the whole row
// shifts at once for any position. The removed value is read out of the row
// at the decoded index and registered.
//
// Reset (synchronous, active low) clears the entry count and the result
// strobe. Cell contents are left as they are; only cells below the count
// are ever read.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire t_cmd    i_cmd,
    output logic         busy,
    output logic         o_done,
    output t_result      o_result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    // list length
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // result register
    logic             r_done;
    t_result          r_result;

    // decoded command
    logic             xfer;
    t_dec             dec;
    logic [IDX_W-1:0] idx;
    t_cell_cmd        cell_cmd;

    logic signed [DATA_W-1:0] cell_val [CAPACITY];

    // one command per clock, never held off
    assign busy = 1'b0;
    assign xfer = start && !busy;

    ple_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .i_valid     (xfer),
        .i_cmd       (i_cmd),
        .i_count     (r_count),
        .o_dec       (dec),
        .o_idx       (idx),
        .o_count_nxt (n_count)
    );

    assign cell_cmd.op    = dec.op;
    assign cell_cmd.value = i_cmd.item_value;

    // row of cells; cell 0 is the front of the list
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] left_val;
        logic signed [DATA_W-1:0] right_val;

        if (g == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_inner_l
            assign left_val = cell_val[g-1];
        end

        // last cell keeps its value on a removal; it falls past the count
        if (g == CAPACITY - 1) begin : g_last
            assign right_val = cell_val[g];
        end else begin : g_inner_r
            assign right_val = cell_val[g+1];
        end

        ple_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cell_cmd),
            .i_idx   (idx),
            .i_left  (left_val),
            .i_right (right_val),
            .o_value (cell_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= xfer;
        end
    end

    // payload: removed value read at the decoded index before the shift
    always_ff @(posedge i_clk) begin
        r_result.removed_value <= (dec.op == SH_REMOVE) ? cell_val[idx] : '0;
        r_result.status        <= dec.status;
        r_result.entry_count   <= CNT_OUT_W'(n_count);
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // count stays within the row
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a result strobe only follows a command transfer
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(xfer))
        else $error("result strobe without command");

    // a full status only when the list really is full
    a_full_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_result.status == ST_FULL)) |-> (r_count == CNT_W'(CAPACITY)))
        else $error("full status on a list with room");

    // insert grows the list by one
    a_ins_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dec.op == SH_INSERT) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the list");

    // remove shrinks the list by one
    a_del_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dec.op == SH_REMOVE) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("remove did not shrink the list");

endmodule

`default_nettype wire

// ===== tb/positional_list_engine_tb.sv =====
`default_nettype none

// Self-checking bench for the positional list engine.
//
// Commands go in through the start/busy handshake; every command transfer
// produces exactly one result, flagged by o_done.
// The bench keeps its own copy of the list as a queue, updates it at each
// command transfer and pushes the predicted result into a FIFO. A monitor
// pops the FIFO on every o_done and compares removed value, status and count.
//
// Sequence: directed corner cases, a fill-to-capacity pass, then a long run
// of random commands that swings the list between empty and full.
module positional_list_engine_tb;
    import ple_pkg::*;

    localparam int CAPACITY   = CAPACITY_DEF;
    localparam int RAND_ITEMS = 640;
    localparam int IDLE_PCT   = 12;
    localparam int STALL_MAX  = 1000;   // cycles without any transfer
    localparam int MAX_REPORT = 10;

    // action codes the block treats as no-ops
    localparam logic [ACT_W-1:0] ACT_NOP6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_NOP7 = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    t_cmd    i_cmd;
    logic    busy;
    logic    o_done;
    t_result o_result;

    positional_list_engine #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow list and pending results
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] shadow_list[$];   // index 0 is the front
    t_result                  pending_results[$];

    int  mismatches;
    int  failures;
    bit  no_gaps;        // suppresses sender idle cycles

    // run statistics
    int  n_cmds;
    int  n_inserts;
    int  n_removes;
    int  n_nops;
    int  n_status[4];
    int  peak_count;
    int  n_results;

    // Applies one command to the shadow list and returns what the block
    // must report. The bad-position test comes before the full test on
    // inserts; on removes an empty list wins over a bad position.
    function automatic t_result apply_to_list(input t_cmd cmd);
        t_result r;
        int      n;
        int      p;
        r = '0;
        n = shadow_list.size();
        p = int'(cmd.position);
        r.status = ST_OK;
        case (cmd.action)
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
                if (cmd.action == ACT_INS_POS && (p == 0 || p > n + 1)) begin
                    r.status = ST_BADPOS;
                end else if (n >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (cmd.action == ACT_INS_FRONT) begin
                    shadow_list.push_front(cmd.item_value);
                end else if (cmd.action == ACT_INS_BACK) begin
                    shadow_list.push_back(cmd.item_value);
                end else begin
                    shadow_list.insert(p - 1, cmd.item_value);
                end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_POS: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else if (cmd.action == ACT_DEL_POS && (p == 0 || p > n)) begin
                    r.status = ST_BADPOS;
                end else if (cmd.action == ACT_DEL_FRONT) begin
                    r.removed_value = shadow_list.pop_front();
                end else if (cmd.action == ACT_DEL_BACK) begin
                    r.removed_value = shadow_list.pop_back();
                end else begin
                    r.removed_value = shadow_list[p - 1];
                    shadow_list.delete(p - 1);
                end
            end
            default: ;  // no-op codes
        endcase
        r.entry_count = CNT_OUT_W'(shadow_list.size());
        return r;
    endfunction

    function automatic t_cmd make_cmd(input logic [ACT_W-1:0] act,
                                      input logic signed [DATA_W-1:0] val,
                                      input int pos);
        t_cmd c;
        c.action     = act;
        c.item_value = val;
        c.position   = POS_W'(pos);
        return c;
    endfunction

    // Value mix: mostly random, now and then an extreme.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: one command per call, with optional idle gap in front.
    // Start stays high across back-to-back calls; the sender only drops it for a gap.
    // ------------------------------------------------------------------
    task automatic send_cmd(input t_cmd cmd);
        t_result exp_r;
        if (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        // transfer happened at this edge
        exp_r = apply_to_list(cmd);
        pending_results.push_back(exp_r);
        n_cmds++;
        case (cmd.action)
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: n_inserts++;
            ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_POS: n_removes++;
            default:                                  n_nops++;
        endcase
        n_status[exp_r.status]++;
        if (shadow_list.size() > peak_count) peak_count = shadow_list.size();
    endtask

    // Holds off the sender until every outstanding result is back.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            n_results++;
            if (pending_results.size() == 0) begin
                failures++;
                if (mismatches < MAX_REPORT)
                    $display("[%0t] unexpected result: removed=%0d status=%0d count=%0d",
                             $realtime, o_result.removed_value, o_result.status,
                             o_result.entry_count);
                mismatches++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_result.removed_value !== exp_r.removed_value ||
                    o_result.status !== exp_r.status ||
                    o_result.entry_count !== exp_r.entry_count) begin
                    failures++;
                    if (mismatches < MAX_REPORT)
                        $display({"[%0t] result mismatch: removed exp %0d got %0d, ",
                                  "status exp %0d got %0d, count exp %0d got %0d"},
                                 $realtime, exp_r.removed_value, o_result.removed_value,
                                 exp_r.status, o_result.status,
                                 exp_r.entry_count, o_result.entry_count);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: counts cycles with neither a command nor a result transfer
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("watchdog: no transfer in %0d cycles", STALL_MAX);
            $display("positional_list_engine regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corners around an empty and a short list: removes on empty (also with
    // a bad position), bad insert positions, position-1 insert, extremes,
    // no-op codes and every remove flavor.
    task automatic test_corner_cases();
        int n;
        send_cmd(make_cmd(ACT_DEL_FRONT, pick_value(), 0));
        send_cmd(make_cmd(ACT_DEL_BACK, pick_value(), 1));
        send_cmd(make_cmd(ACT_DEL_POS, pick_value(), 0));
        send_cmd(make_cmd(ACT_DEL_POS, pick_value(), 127));   // empty beats bad pos
        send_cmd(make_cmd(ACT_INS_POS, 32'sd5, 0));
        send_cmd(make_cmd(ACT_INS_POS, 32'sd5, 2));
        send_cmd(make_cmd(ACT_INS_POS, 32'sd7, 1));            // into empty list
        send_cmd(make_cmd(ACT_INS_FRONT, VAL_MAX, 0));
        send_cmd(make_cmd(ACT_INS_BACK, VAL_MIN, 127));
        n = shadow_list.size();
        send_cmd(make_cmd(ACT_INS_POS, -32'sd1, n + 1));       // append by position
        send_cmd(make_cmd(ACT_INS_POS, 32'sd0, 1));            // position 1 = front
        send_cmd(make_cmd(ACT_INS_POS, 32'sh5555_5555, 3));
        send_cmd(make_cmd(ACT_INS_POS, 32'sh2aaa_aaaa, 127));
        n = shadow_list.size();
        send_cmd(make_cmd(ACT_INS_POS, pick_value(), n + 2));
        send_cmd(make_cmd(ACT_NOP6, $urandom, $urandom_range(0, 127)));
        send_cmd(make_cmd(ACT_NOP7, $urandom, $urandom_range(0, 127)));
        n = shadow_list.size();
        send_cmd(make_cmd(ACT_DEL_POS, pick_value(), 0));
        send_cmd(make_cmd(ACT_DEL_POS, pick_value(), n + 1));
        send_cmd(make_cmd(ACT_DEL_POS, pick_value(), n));      // last entry
        send_cmd(make_cmd(ACT_DEL_POS, pick_value(), 1));      // first entry
        send_cmd(make_cmd(ACT_DEL_POS, pick_value(), 2));
        send_cmd(make_cmd(ACT_DEL_FRONT, pick_value(), 0));
        send_cmd(make_cmd(ACT_DEL_BACK, pick_value(), 0));
    endtask

    // Fill to capacity, hit the full list with every insert flavor, then
    // drain it completely and remove once more from empty.
    task automatic test_full_list();
        int n;
        while (shadow_list.size() < CAPACITY) begin
            n = shadow_list.size();
            case ($urandom_range(0, 2))
                0:       send_cmd(make_cmd(ACT_INS_FRONT, pick_value(), 0));
                1:       send_cmd(make_cmd(ACT_INS_BACK, pick_value(), 0));
                default: send_cmd(make_cmd(ACT_INS_POS, pick_value(),
                                           $urandom_range(1, n + 1)));
            endcase
        end
        n = shadow_list.size();
        send_cmd(make_cmd(ACT_INS_FRONT, pick_value(), 0));
        send_cmd(make_cmd(ACT_INS_BACK, pick_value(), 0));
        send_cmd(make_cmd(ACT_INS_POS, pick_value(), 1));
        send_cmd(make_cmd(ACT_INS_POS, pick_value(), n + 1));  // valid slot, list full
        send_cmd(make_cmd(ACT_INS_POS, pick_value(), n + 2));  // bad pos wins over full
        send_cmd(make_cmd(ACT_INS_POS, pick_value(), 0));
        send_cmd(make_cmd(ACT_DEL_POS, pick_value(), n + 1));
        send_cmd(make_cmd(ACT_DEL_POS, pick_value(), n));
        send_cmd(make_cmd(ACT_INS_POS, pick_value(), n));      // refill last slot
        while (shadow_list.size() > 0) begin
            n = shadow_list.size();
            case ($urandom_range(0, 2))
                0:       send_cmd(make_cmd(ACT_DEL_FRONT, pick_value(), 0));
                1:       send_cmd(make_cmd(ACT_DEL_BACK, pick_value(), 0));
                default: send_cmd(make_cmd(ACT_DEL_POS, pick_value(),
                                           $urandom_range(1, n)));
            endcase
        end
        send_cmd(make_cmd(ACT_DEL_BACK, pick_value(), 0));
    endtask

    // Random traffic in segments with shifting insert/remove bias, so the
    // list keeps swinging between empty and full. One segment runs with
    // no sender gaps at all.
    task automatic test_random_traffic(input int n_items);
        int               grow_pct;
        int               n;
        int               pos;
        int               sel;
        logic [ACT_W-1:0] act;
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 0) begin
                case ((i / 100) % 6)
                    0:       grow_pct = 80;
                    1:       grow_pct = 20;
                    2:       grow_pct = 95;
                    3:       grow_pct = 5;
                    default: grow_pct = 50;
                endcase
                no_gaps = ((i / 100) == 4);
            end
            n   = shadow_list.size();
            sel = $urandom_range(0, 2);
            if ($urandom_range(0, 99) < 3) begin
                act = $urandom_range(0, 1) ? ACT_NOP7 : ACT_NOP6;
            end else if ($urandom_range(0, 99) < grow_pct) begin
                act = (sel == 0) ? ACT_INS_FRONT : (sel == 1) ? ACT_INS_BACK : ACT_INS_POS;
            end else begin
                act = (sel == 0) ? ACT_DEL_FRONT : (sel == 1) ? ACT_DEL_BACK : ACT_DEL_POS;
            end
            // positions: mostly in range for the action, some zero, some anywhere
            case ($urandom_range(0, 19))
                0:       pos = 0;
                1, 2:    pos = $urandom_range(0, 127);
                default: pos = (act == ACT_DEL_POS) ? $urandom_range(1, (n > 0) ? n : 1)
                                                    : $urandom_range(1, n + 1);
            endcase
            send_cmd(make_cmd(act, pick_value(), pos));
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cmd        = '0;
        mismatches   = 0;
        failures     = 0;
        no_gaps      = 1'b0;
        n_cmds       = 0;
        n_inserts    = 0;
        n_removes    = 0;
        n_nops       = 0;
        n_status     = '{default: 0};
        peak_count   = 0;
        n_results    = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_cases();
        drain_results();
        test_full_list();
        drain_results();
        test_random_traffic(RAND_ITEMS);

        // let the last result arrive, then a few spare cycles
        drain_results();
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            failures++;
            $display("%0d results never arrived", pending_results.size());
        end

        $display("%0d commands (%0d inserts, %0d removes, %0d no-ops), %0d results, peak %0d/%0d",
                 n_cmds, n_inserts, n_removes, n_nops, n_results, peak_count, CAPACITY);
        $display("status mix ok/empty/bad-pos/full: %0d/%0d/%0d/%0d, %0d mismatches",
                 n_status[ST_OK], n_status[ST_EMPTY], n_status[ST_BADPOS],
                 n_status[ST_FULL], mismatches);
        if (failures == 0) begin
            $display("positional_list_engine regression: pass");
        end else begin
            $display("positional_list_engine regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
